### src/rrs_pkg.sv
package rrs_pkg;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned PID_W  = 5;

  localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic disp;
    logic scan;
  } rrs_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic work_empty;
    logic hit;
  } rrs_sts_t;

endpackage

### src/round_robin_slice_scheduler_top.sv
// Round-robin time-slice scheduler. Pulse start_i with kind_i to clear the table, append one
// burst (dropped when the table holds MAX_PROCESSES entries) or dispatch one slice. Clear and
// load take effect at the accepting edge and give no result, and busy_o stays low for them.
// A dispatch walks the table from the current position through a registered-read RAM, one entry
// per cycle, so it raises busy_o for longer the more finished entries precede the next one with
// work; valid_o then pulses for one cycle with the result. A dispatch with no work pending
// answers all done on the next cycle. The receiver cannot stall: sample the result while
// valid_o is high. A new request may be given in the cycle that valid_o is high. Write
// quantum only while no dispatch is in progress.
module round_robin_slice_scheduler_top
  import rrs_pkg::*;
#(
  parameter int unsigned MAX_PROCESSES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [TIME_W-1:0] burst_i,
  input  logic              quantum_we_i,
  input  logic [TIME_W-1:0] quantum_i,
  output logic              valid_o,
  output logic [PID_W-1:0]  process_id_o,
  output logic [TIME_W-1:0] ran_for_o,
  output logic              process_finished_o,
  output logic              all_done_o
);

  rrs_cmd_t cmd;
  rrs_sts_t sts;

  rrs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .kind_i  (kind_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .valid_o (valid_o)
  );

  rrs_dpath #(
    .MAX_PROCESSES(MAX_PROCESSES)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .burst_i            (burst_i),
    .quantum_we_i       (quantum_we_i),
    .quantum_i          (quantum_i),
    .process_id_o       (process_id_o),
    .ran_for_o          (ran_for_o),
    .process_finished_o (process_finished_o),
    .all_done_o         (all_done_o)
  );

endmodule

### src/rrs_ram.sv
module rrs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/rrs_ctrl.sv
module rrs_ctrl
  import rrs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [KIND_W-1:0] kind_i,
  input  rrs_sts_t          sts_i,
  output rrs_cmd_t          cmd_o,
  output logic              busy_o,
  output logic              valid_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign busy_o  = (state_q == ST_SCAN);
  assign valid_o = (state_q == ST_RESP);
  assign accept  = start_i && !busy_o;

  assign cmd_o.clear = accept && (kind_i == KIND_CLEAR);
  assign cmd_o.load  = accept && (kind_i == KIND_LOAD);
  assign cmd_o.disp  = accept && (kind_i == KIND_DISPATCH);
  assign cmd_o.scan  = (state_q == ST_SCAN);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE, ST_RESP: begin
        if (cmd_o.disp) begin
          // nothing left to run: answer at once
          state_d = sts_i.work_empty ? ST_RESP : ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (sts_i.hit) begin
          state_d = ST_RESP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o || (start_i && kind_i == KIND_DISPATCH)))
    else $error("result without a dispatch");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && kind_i == KIND_DISPATCH && !sts_i.work_empty))
    else $error("scan started without pending work");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && sts_i.hit) |=> valid_o)
    else $error("hit not reported");
`endif

endmodule

### src/rrs_dpath.sv
module rrs_dpath
  import rrs_pkg::*;
#(
  parameter int unsigned MAX_PROCESSES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rrs_cmd_t          cmd_i,
  output rrs_sts_t          sts_o,
  input  logic [TIME_W-1:0] burst_i,
  input  logic              quantum_we_i,
  input  logic [TIME_W-1:0] quantum_i,
  output logic [PID_W-1:0]  process_id_o,
  output logic [TIME_W-1:0] ran_for_o,
  output logic              process_finished_o,
  output logic              all_done_o
);

  localparam int unsigned IDX_W = $clog2(MAX_PROCESSES);
  localparam int unsigned CNT_W = $clog2(MAX_PROCESSES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCESSES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_PROCESSES);

  logic [TIME_W-1:0]        quantum_q;
  logic [CNT_W-1:0]         loaded_q;
  logic [CNT_W-1:0]         work_q, work_d;
  logic [IDX_W-1:0]         scan_pos_q;
  logic [IDX_W-1:0]         addr_q;
  logic [IDX_W-1:0]         chk_idx_q;
  logic                     chk_vld_q;
  logic [MAX_PROCESSES-1:0] entry_vld_q;

  logic [PID_W-1:0]  pid_q;
  logic [TIME_W-1:0] ran_q;
  logic              fin_q;
  logic              done_q;

  logic              full;
  logic              do_load;
  logic              hit;
  logic [TIME_W-1:0] rd_data;
  logic [TIME_W-1:0] left;
  logic [TIME_W-1:0] q_eff;
  logic [TIME_W-1:0] slice;
  logic [TIME_W-1:0] left_new;
  logic              fin;
  logic [IDX_W:0]    pid_full;
  logic [IDX_W-1:0]  chk_next;
  logic [IDX_W-1:0]  addr_next;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [TIME_W-1:0] ram_wdata;

  assign full    = (loaded_q >= FULL_CNT);
  assign do_load = cmd_i.load && !full;

  // entries not loaded since the last clear read as zero
  assign left     = entry_vld_q[chk_idx_q] ? rd_data : '0;
  assign hit      = cmd_i.scan && chk_vld_q && (left != '0);
  assign q_eff    = (quantum_q == '0) ? TIME_W'(1) : quantum_q;
  assign slice    = (left < q_eff) ? left : q_eff;
  assign left_new = left - slice;
  assign fin      = (left_new == '0);
  assign pid_full = {1'b0, chk_idx_q} + (IDX_W + 1)'(1);
  assign chk_next = (chk_idx_q == LAST_IDX) ? '0 : chk_idx_q + IDX_W'(1);
  assign addr_next = (addr_q == LAST_IDX) ? '0 : addr_q + IDX_W'(1);

  assign sts_o.hit        = hit;
  assign sts_o.work_empty = (work_q == '0);

  assign ram_we    = do_load || hit;
  assign ram_waddr = cmd_i.load ? loaded_q[IDX_W-1:0] : chk_idx_q;
  assign ram_wdata = cmd_i.load ? burst_i : left_new;

  rrs_ram #(
    .WIDTH(TIME_W),
    .DEPTH(MAX_PROCESSES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (rd_data)
  );

  always_comb begin
    work_d = work_q;
    if (cmd_i.clear) begin
      work_d = '0;
    end else if (do_load && (burst_i != '0)) begin
      work_d = work_q + CNT_W'(1);
    end else if (hit && fin) begin
      work_d = work_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q   <= TIME_W'(1);
      loaded_q    <= '0;
      work_q      <= '0;
      scan_pos_q  <= '0;
      addr_q      <= '0;
      chk_idx_q   <= '0;
      chk_vld_q   <= 1'b0;
      entry_vld_q <= '0;
    end else begin
      if (quantum_we_i) begin
        quantum_q <= quantum_i;
      end
      work_q <= work_d;
      if (cmd_i.clear) begin
        loaded_q    <= '0;
        scan_pos_q  <= '0;
        entry_vld_q <= '0;
      end else if (do_load) begin
        loaded_q <= loaded_q + CNT_W'(1);
        entry_vld_q[loaded_q[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd_i.disp) begin
        addr_q    <= scan_pos_q;
        chk_vld_q <= 1'b0;
      end else if (cmd_i.scan) begin
        // one read issued per cycle, checked in the next cycle
        addr_q    <= addr_next;
        chk_idx_q <= addr_q;
        chk_vld_q <= !hit;
      end
      if (hit) begin
        scan_pos_q <= chk_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.disp && sts_o.work_empty) begin
      pid_q  <= '0;
      ran_q  <= '0;
      fin_q  <= 1'b0;
      done_q <= 1'b1;
    end else if (hit) begin
      pid_q  <= PID_W'(pid_full);
      ran_q  <= slice;
      fin_q  <= fin;
      done_q <= (work_d == '0);
    end
  end

  assign process_id_o       = pid_q;
  assign ran_for_o          = ran_q;
  assign process_finished_o = fin_q;
  assign all_done_o         = done_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= FULL_CNT)
    else $error("load count beyond table size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_q <= loaded_q)
    else $error("more pending entries than loaded");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> (work_q != '0))
    else $error("hit while no work pending");
`endif

endmodule

### bench/tb_top.sv
module tb_top;
  import rrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PROCESSES = 16;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [TIME_W-1:0] ran_for;
    logic              finished;
    logic              all_done;
  } slice_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [KIND_W-1:0] kind_i;
  logic [TIME_W-1:0] burst_i;
  logic              quantum_we_i;
  logic [TIME_W-1:0] quantum_i;
  logic              valid_o;
  logic [PID_W-1:0]  process_id_o;
  logic [TIME_W-1:0] ran_for_o;
  logic              process_finished_o;
  logic              all_done_o;

  // scheduler state as the bench sees it
  logic [TIME_W-1:0] burst_left [MAX_PROCESSES];
  int unsigned       n_loaded;
  int unsigned       scan_at;
  logic [TIME_W-1:0] quantum_set;

  slice_t      expected_slices[$];
  int unsigned idle_pct;
  int unsigned n_requests;
  int unsigned n_slices_checked;
  int unsigned n_quantum_writes;
  int unsigned n_mismatch;

  round_robin_slice_scheduler_top #(
    .MAX_PROCESSES(MAX_PROCESSES)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .kind_i            (kind_i),
    .burst_i           (burst_i),
    .quantum_we_i      (quantum_we_i),
    .quantum_i         (quantum_i),
    .valid_o           (valid_o),
    .process_id_o      (process_id_o),
    .ran_for_o         (ran_for_o),
    .process_finished_o(process_finished_o),
    .all_done_o        (all_done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void predict_slice(input logic [KIND_W-1:0] kind,
                                        input logic [TIME_W-1:0] burst);
    slice_t            res;
    logic [TIME_W-1:0] q;
    logic [TIME_W-1:0] left;
    int unsigned       idx;
    bit                found;
    case (kind)
      KIND_CLEAR: begin
        foreach (burst_left[i]) burst_left[i] = '0;
        n_loaded = 0;
        scan_at  = 0;
      end
      KIND_LOAD: begin
        if (n_loaded < MAX_PROCESSES) begin
          burst_left[n_loaded] = burst;
          n_loaded++;
        end
      end
      KIND_DISPATCH: begin
        res   = '{pid: '0, ran_for: '0, finished: 1'b0, all_done: 1'b1};
        found = 1'b0;
        for (int k = 0; k < MAX_PROCESSES && !found; k++) begin
          idx = (scan_at + k) % MAX_PROCESSES;
          if (burst_left[idx] != '0) begin
            found           = 1'b1;
            q               = (quantum_set == '0) ? TIME_W'(1) : quantum_set;
            left            = burst_left[idx];
            res.ran_for     = (left < q) ? left : q;
            burst_left[idx] = left - res.ran_for;
            scan_at         = (idx + 1) % MAX_PROCESSES;
            res.pid         = PID_W'(idx + 1);
            res.finished    = (burst_left[idx] == '0);
            foreach (burst_left[i]) begin
              if (burst_left[i] != '0) res.all_done = 1'b0;
            end
          end
        end
        expected_slices.insert(expected_slices.size(), res);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_burst();
    int unsigned q;
    int unsigned top;
    q   = (quantum_set == '0) ? 1 : quantum_set;
    top = 3 * q;
    if (top > 65535) top = 65535;
    case ($urandom_range(9))
      0:       return '0;
      1:       return TIME_W'($urandom);
      default: return TIME_W'($urandom_range(1, top));
    endcase
  endfunction

  // call at a rising edge; returns at the edge that accepted the request
  task automatic issue(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] burst);
    start_i <= 1'b1;
    kind_i  <= kind;
    burst_i <= burst;
    do @(posedge clk_i); while (busy_o);
    predict_slice(kind, burst);
    n_requests++;
  endtask

  task automatic sender_gap();
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      kind_i  <= KIND_W'($urandom);
      burst_i <= TIME_W'($urandom);
      @(posedge clk_i);
    end
  endtask

  task automatic settle();
    start_i <= 1'b0;
    while (expected_slices.size() != 0) @(posedge clk_i);
    // idle wait before the next phase
    repeat (MAX_PROCESSES + 4) @(posedge clk_i);
  endtask

  task automatic set_quantum(input logic [TIME_W-1:0] value);
    settle();
    quantum_we_i <= 1'b1;
    quantum_i    <= value;
    @(posedge clk_i);
    quantum_we_i <= 1'b0;
    quantum_i    <= TIME_W'($urandom);
    quantum_set  = value;
    n_quantum_writes++;
  endtask

  task automatic test_empty_and_ignored();
    issue(KIND_DISPATCH, 16'h1234);
    issue(KIND_UNUSED, 16'hFFFF);
    issue(KIND_CLEAR, 16'h0000);
    issue(KIND_DISPATCH, 16'h0000);
  endtask

  task automatic test_quantum_extremes();
    set_quantum(16'd1);
    issue(KIND_LOAD, 16'd0);
    issue(KIND_LOAD, 16'd2);
    issue(KIND_LOAD, 16'hFFFF);
    issue(KIND_DISPATCH, 16'd0);
    issue(KIND_DISPATCH, 16'd0);
    set_quantum(16'hFFFF);
    issue(KIND_DISPATCH, 16'd0);
    issue(KIND_DISPATCH, 16'd0);
    issue(KIND_DISPATCH, 16'd0);
  endtask

  task automatic test_full_table();
    set_quantum(16'd0);
    issue(KIND_CLEAR, 16'd0);
    for (int i = 0; i < MAX_PROCESSES; i++) begin
      issue(KIND_LOAD, (i % 3 == 0) ? 16'd0 : TIME_W'(i));
    end
    // table full, this burst must be dropped
    issue(KIND_LOAD, 16'hFFFF);
    repeat (3) issue(KIND_DISPATCH, 16'd0);
  endtask

  task automatic test_slice_traffic(input int unsigned items, input int unsigned pct);
    int unsigned          done;
    int unsigned          n_procs;
    int unsigned          n_disp;
    logic [KIND_W-1:0]    kind;
    idle_pct = pct;
    done     = 0;
    while (done < items) begin
      if ($urandom_range(99) < 12) begin
        kind = KIND_W'($urandom_range(3));
        sender_gap();
        issue(kind, TIME_W'($urandom));
        if (kind != KIND_UNUSED) done++;
      end else begin
        n_procs = $urandom_range(1, MAX_PROCESSES + 2);
        n_disp  = $urandom_range(n_procs, 3 * n_procs + 3);
        sender_gap();
        issue(KIND_CLEAR, TIME_W'($urandom));
        repeat (n_procs) begin
          sender_gap();
          issue(KIND_LOAD, pick_burst());
        end
        repeat (n_disp) begin
          sender_gap();
          // late appends while slices are being handed out
          if ($urandom_range(9) == 0) begin
            issue(KIND_LOAD, pick_burst());
            sender_gap();
            done++;
          end
          issue(KIND_DISPATCH, TIME_W'($urandom));
        end
        done += 1 + n_procs + n_disp;
      end
    end
    settle();
    idle_pct = 0;
  endtask

  always @(posedge clk_i) begin
    slice_t got;
    slice_t want;
    if (rst_ni && valid_o) begin
      got = '{pid: process_id_o, ran_for: ran_for_o,
              finished: process_finished_o, all_done: all_done_o};
      if (expected_slices.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("%0t: unexpected result pid %0d ran_for %0d finished %0b all_done %0b",
                   $realtime, got.pid, got.ran_for, got.finished, got.all_done);
        end
      end else begin
        want = expected_slices.pop_front();
        n_slices_checked++;
        if (got.pid !== want.pid || got.ran_for !== want.ran_for ||
            got.finished !== want.finished || got.all_done !== want.all_done) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("%0t: result mismatch exp pid %0d ran_for %0d fin %0b done %0b",
                     $realtime, want.pid, want.ran_for, want.finished, want.all_done);
            $display("%0t:                 got pid %0d ran_for %0d fin %0b done %0b",
                     $realtime, got.pid, got.ran_for, got.finished, got.all_done);
          end
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", expected_slices.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    kind_i       <= KIND_CLEAR;
    burst_i      <= '0;
    quantum_we_i <= 1'b0;
    quantum_i    <= '0;
    foreach (burst_left[i]) burst_left[i] = '0;
    n_loaded         = 0;
    scan_at          = 0;
    quantum_set      = 16'd1;
    idle_pct         = 0;
    n_requests       = 0;
    n_slices_checked = 0;
    n_quantum_writes = 0;
    n_mismatch       = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_ignored();
    test_quantum_extremes();
    test_full_table();

    set_quantum(16'd1);
    test_slice_traffic(250, 0);
    set_quantum(16'hFFFF);
    test_slice_traffic(250, 51);
    set_quantum(16'd0);
    test_slice_traffic(200, 7);
    set_quantum(16'd3);
    test_slice_traffic(250, 0);
    set_quantum(TIME_W'($urandom));
    test_slice_traffic(250, 51);
    set_quantum(TIME_W'($urandom_range(2, 20)));
    test_slice_traffic(250, 7);

    settle();
    $display("sent %0d requests, checked %0d dispatch results", n_requests, n_slices_checked);
    $display("quantum written %0d times, including 0, 1 and 65535; %0d mismatches",
             n_quantum_writes, n_mismatch);
    if (n_mismatch == 0 && expected_slices.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
